[rtl/tesw_pkg.sv]
// Shared types and constants for the tar entry stream walker.
// No dependencies; imported by every module of the block.
package tesw_pkg;

  localparam int SIZE_DIGITS_DEF   = 11;
  localparam int NAME_LIMIT_DEF    = 99;
  localparam int INDEX_BITS_DEF    = 16;
  localparam int POSITION_BITS_DEF = 40;

  localparam int BLOCK_BYTES = 512;
  localparam int SIZE_START  = 124;

  localparam int BYTE_W   = 8;
  localparam int OFFS_W   = 9;
  localparam int SIZE_W   = 33;
  localparam int REMAIN_W = 34;
  localparam int IDX_W    = 16;
  localparam int OFFSET_W = 40;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ARCHIVE_PRESENT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIST_ALL        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_INDEX    = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_NAME  = 2'd0;
  localparam logic [1:0] KIND_ENTRY = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  localparam logic [BYTE_W-1:0] CHR_NUL   = 8'h00;
  localparam logic [BYTE_W-1:0] CHR_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CHR_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CHR_SEVEN = 8'h37;

  typedef struct packed {
    logic [1:0]          kind;
    logic [BYTE_W-1:0]   name_char;
    logic [IDX_W-1:0]    entry_index;
    logic [SIZE_W-1:0]   entry_size;
    logic [OFFSET_W-1:0] data_offset;
    logic                size_error;
    logic                found;
  } res_t;

endpackage

[rtl/tesw_in_reg.sv]
// Input request register of the tar walker.
// Depends on tesw_pkg for field widths.
module tesw_in_reg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [tesw_pkg::BYTE_W-1:0] in_archive_byte,
  input  logic                       in_start_req,
  input  logic                       adv,
  output logic                       item_valid,
  output logic [tesw_pkg::BYTE_W-1:0] item_byte,
  output logic                       item_start
);
  import tesw_pkg::*;

  logic              valid_r;
  logic [BYTE_W-1:0] byte_r;
  logic              start_r;

  assign in_ready = !valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_r  <= in_archive_byte;
      start_r <= in_start_req;
    end
  end

  assign item_valid = valid_r;
  assign item_byte  = byte_r;
  assign item_start = start_r;

endmodule

[rtl/tesw_core.sv]
// Walker state, configuration registers and per-byte update logic.
// Depends on tesw_pkg for widths, codes and the result struct.
module tesw_core #(
  parameter int SIZE_DIGITS   = tesw_pkg::SIZE_DIGITS_DEF,
  parameter int NAME_LIMIT    = tesw_pkg::NAME_LIMIT_DEF,
  parameter int INDEX_BITS    = tesw_pkg::INDEX_BITS_DEF,
  parameter int POSITION_BITS = tesw_pkg::POSITION_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [tesw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tesw_pkg::CFG_DAT_W-1:0] cfg_data,
  input  logic                          adv,
  input  logic [tesw_pkg::BYTE_W-1:0]   item_byte,
  input  logic                          item_start,
  output logic                          res_valid,
  output tesw_pkg::res_t                res
);
  import tesw_pkg::*;

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_DATA   = 2'd1;
  localparam logic [1:0] PH_ENDED  = 2'd2;

  localparam int CMP_W = (INDEX_BITS > IDX_W) ? INDEX_BITS : IDX_W;
  localparam int PW    = (POSITION_BITS > OFFSET_W) ? POSITION_BITS : OFFSET_W;
  localparam logic [OFFS_W-1:0] NAME_END  = OFFS_W'(NAME_LIMIT);
  localparam logic [OFFS_W-1:0] SIZE_BEG  = OFFS_W'(SIZE_START);
  localparam logic [OFFS_W-1:0] SIZE_LAST = OFFS_W'(SIZE_START + SIZE_DIGITS - 1);
  localparam logic [OFFS_W-1:0] LAST_OFFS = OFFS_W'(BLOCK_BYTES - 1);

  // configuration
  logic              present_r;
  logic              list_all_r;
  logic [IDX_W-1:0]  target_r;

  // walk state
  logic [1:0]               phase_r, phase_nxt, phase_c;
  logic [OFFS_W-1:0]        boff_r, boff_nxt, boff_c;
  logic [REMAIN_W-1:0]      drem_r, drem_nxt, drem_c, drem_dec;
  logic [SIZE_W-1:0]        sacc_r, sacc_nxt, sacc_c;
  logic                     sstop_r, sstop_nxt, sstop_c;
  logic                     sbad_r, sbad_nxt, sbad_c;
  logic                     nstop_r, nstop_nxt, nstop_c;
  logic [INDEX_BITS-1:0]    ecnt_r, ecnt_nxt, ecnt_c;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt, pos_c, pos_inc;
  logic                     tseen_r, tseen_nxt, tseen_c;

  logic [CMP_W-1:0]    ecnt_ext, target_ext;
  logic [PW-1:0]       pos_ext;
  logic                is_target, selected;
  logic [SIZE_W-1:0]   digit;
  logic [SIZE_W+2:0]   full;
  logic                octal;
  logic [REMAIN_W-1:0] rounded;
  logic                res_vld_c;
  res_t                res_c;

  // a start request restarts from a cleared walk
  assign phase_c = item_start ? PH_HEADER : phase_r;
  assign boff_c  = item_start ? '0 : boff_r;
  assign drem_c  = item_start ? '0 : drem_r;
  assign sacc_c  = item_start ? '0 : sacc_r;
  assign sstop_c = item_start ? 1'b0 : sstop_r;
  assign sbad_c  = item_start ? 1'b0 : sbad_r;
  assign nstop_c = item_start ? 1'b0 : nstop_r;
  assign ecnt_c  = item_start ? '0 : ecnt_r;
  assign pos_c   = item_start ? '0 : pos_r;
  assign tseen_c = item_start ? 1'b0 : tseen_r;

  assign ecnt_ext   = CMP_W'(ecnt_c);
  assign target_ext = CMP_W'(target_r);
  assign is_target  = (ecnt_ext == target_ext);
  assign selected   = list_all_r || is_target;

  assign pos_inc  = pos_c + POSITION_BITS'(1);
  assign pos_ext  = PW'(pos_inc);
  assign drem_dec = drem_c - REMAIN_W'(1);

  // digit wraps like (char - '0') mod 2^33
  assign digit = SIZE_W'(item_byte) - SIZE_W'(CHR_ZERO);
  assign full  = {sacc_c, 3'b000} + (SIZE_W+3)'(digit);
  assign octal = item_byte inside {[CHR_ZERO:CHR_SEVEN]};

  // data length rounded up to whole blocks
  assign rounded = (REMAIN_W'(sacc_c) + REMAIN_W'(BLOCK_BYTES - 1))
                 & ~REMAIN_W'(BLOCK_BYTES - 1);

  always_comb begin
    phase_nxt = phase_c;
    boff_nxt  = boff_c;
    drem_nxt  = drem_c;
    sacc_nxt  = sacc_c;
    sstop_nxt = sstop_c;
    sbad_nxt  = sbad_c;
    nstop_nxt = nstop_c;
    ecnt_nxt  = ecnt_c;
    pos_nxt   = pos_c;
    tseen_nxt = tseen_c;
    res_vld_c = 1'b0;
    res_c     = '0;

    if (item_start && !present_r) begin
      phase_nxt  = PH_ENDED;
      res_vld_c  = 1'b1;
      res_c.kind = KIND_END;
    end else if (present_r) begin
      case (phase_c)
        PH_DATA: begin
          pos_nxt  = pos_inc;
          drem_nxt = drem_dec;
          if (drem_dec == '0) begin
            phase_nxt = PH_HEADER;
            boff_nxt  = '0;
          end
        end
        PH_HEADER: begin
          if (boff_c == '0 && item_byte == CHR_NUL) begin
            // NUL first header byte: end of archive
            phase_nxt         = PH_ENDED;
            res_vld_c         = 1'b1;
            res_c.kind        = KIND_END;
            res_c.entry_index = ecnt_ext[IDX_W-1:0];
            res_c.found       = tseen_c;
          end else begin
            if (boff_c < NAME_END && !nstop_c) begin
              if (item_byte == CHR_NUL) begin
                nstop_nxt = 1'b1;
              end else if (selected) begin
                res_vld_c         = 1'b1;
                res_c.kind        = KIND_NAME;
                res_c.name_char   = item_byte;
                res_c.entry_index = ecnt_ext[IDX_W-1:0];
              end
            end
            if ((boff_c inside {[SIZE_BEG:SIZE_LAST]}) && !sstop_c) begin
              if (item_byte inside {CHR_NUL, CHR_SPACE}) begin
                sstop_nxt = 1'b1;
              end else begin
                if (!octal || full[SIZE_W+2:SIZE_W] != 3'b000) begin
                  sbad_nxt = 1'b1;
                end
                sacc_nxt = full[SIZE_W-1:0];
              end
            end
            pos_nxt = pos_inc;
            if (boff_c == LAST_OFFS) begin
              if (selected) begin
                res_vld_c         = 1'b1;
                res_c.kind        = KIND_ENTRY;
                res_c.name_char   = '0;
                res_c.entry_index = ecnt_ext[IDX_W-1:0];
                res_c.entry_size  = sacc_c;
                res_c.data_offset = pos_ext[OFFSET_W-1:0];
                res_c.size_error  = sbad_c;
              end
              if (is_target) begin
                tseen_nxt = 1'b1;
              end
              ecnt_nxt  = ecnt_c + INDEX_BITS'(1);
              drem_nxt  = rounded;
              phase_nxt = (rounded != '0) ? PH_DATA : PH_HEADER;
              boff_nxt  = '0;
              sacc_nxt  = '0;
              sstop_nxt = 1'b0;
              sbad_nxt  = 1'b0;
              nstop_nxt = 1'b0;
            end else begin
              boff_nxt = boff_c + OFFS_W'(1);
            end
          end
        end
        default: begin
          // ended: bytes are dropped until the next start
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r  <= 1'b0;
      list_all_r <= 1'b1;
      target_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ARCHIVE_PRESENT: present_r  <= cfg_data[0];
        CFG_LIST_ALL:        list_all_r <= cfg_data[0];
        CFG_TARGET_INDEX:    target_r   <= cfg_data[IDX_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      boff_r  <= '0;
      drem_r  <= '0;
      sacc_r  <= '0;
      sstop_r <= 1'b0;
      sbad_r  <= 1'b0;
      nstop_r <= 1'b0;
      ecnt_r  <= '0;
      pos_r   <= '0;
      tseen_r <= 1'b0;
    end else if (adv) begin
      phase_r <= phase_nxt;
      boff_r  <= boff_nxt;
      drem_r  <= drem_nxt;
      sacc_r  <= sacc_nxt;
      sstop_r <= sstop_nxt;
      sbad_r  <= sbad_nxt;
      nstop_r <= nstop_nxt;
      ecnt_r  <= ecnt_nxt;
      pos_r   <= pos_nxt;
      tseen_r <= tseen_nxt;
    end
  end

  assign res_valid = res_vld_c;
  assign res       = res_c;

endmodule

[rtl/tesw_out_reg.sv]
// Result register of the tar walker; holds one result until taken.
// Depends on tesw_pkg for the result struct.
module tesw_out_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  logic           res_valid,
  input  tesw_pkg::res_t res,
  output logic           slot_free,
  output logic           out_valid,
  input  logic           out_ready,
  output tesw_pkg::res_t out_res
);
  import tesw_pkg::*;

  logic valid_r;
  res_t res_r;

  assign slot_free = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= res_valid;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

[rtl/tar_entry_stream_walker_unit.sv]
// Top level of the tar entry stream walker.
// Depends on tesw_pkg, tesw_in_reg, tesw_core and tesw_out_reg.
//
// Walks a tar archive fed one byte per request and reports name bytes,
// entry completions (index, octal size, data offset, size error) and the
// end of the archive. One byte is taken every cycle unless the result side
// stalls: the whole per-byte update of the walk counters and the size
// accumulator is one pass of logic between the input register and the result
// register, so the block sustains one request per clock when not stalled; a
// result passes the input register, then the result register, to out_valid.
// A byte causes at most one result. When the result register is full and
// out_ready is low the input side stalls; otherwise bytes that produce no
// result pass straight through. No clearing pass is needed after reset.
// Configuration writes land at once and must be made while the block is idle.
module tar_entry_stream_walker_unit #(
  parameter int SIZE_DIGITS   = tesw_pkg::SIZE_DIGITS_DEF,
  parameter int NAME_LIMIT    = tesw_pkg::NAME_LIMIT_DEF,
  parameter int INDEX_BITS    = tesw_pkg::INDEX_BITS_DEF,
  parameter int POSITION_BITS = tesw_pkg::POSITION_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration write port
  input  logic                            cfg_we,
  input  logic [tesw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tesw_pkg::CFG_DAT_W-1:0]  cfg_data,
  // archive byte requests
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [tesw_pkg::BYTE_W-1:0]     in_archive_byte,
  input  logic                            in_start_req,
  // result requests
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      out_kind,
  output logic [tesw_pkg::BYTE_W-1:0]     out_name_char,
  output logic [tesw_pkg::IDX_W-1:0]      out_entry_index,
  output logic [tesw_pkg::SIZE_W-1:0]     out_entry_size,
  output logic [tesw_pkg::OFFSET_W-1:0]   out_data_offset,
  output logic                            out_size_error,
  output logic                            out_found
);
  import tesw_pkg::*;

  logic              item_valid;
  logic [BYTE_W-1:0] item_byte;
  logic              item_start;
  logic              slot_free;
  logic              adv;
  logic              res_valid;
  res_t              res;
  res_t              out_res;

  // the registered byte moves on when the result slot can take its outcome
  assign adv = item_valid && slot_free;

  tesw_in_reg u_in_reg (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_archive_byte(in_archive_byte),
    .in_start_req   (in_start_req),
    .adv            (adv),
    .item_valid     (item_valid),
    .item_byte      (item_byte),
    .item_start     (item_start)
  );

  tesw_core #(
    .SIZE_DIGITS  (SIZE_DIGITS),
    .NAME_LIMIT   (NAME_LIMIT),
    .INDEX_BITS   (INDEX_BITS),
    .POSITION_BITS(POSITION_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .adv       (adv),
    .item_byte (item_byte),
    .item_start(item_start),
    .res_valid (res_valid),
    .res       (res)
  );

  tesw_out_reg u_out_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .res_valid(res_valid),
    .res      (res),
    .slot_free(slot_free),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_res  (out_res)
  );

  assign out_kind        = out_res.kind;
  assign out_name_char   = out_res.name_char;
  assign out_entry_index = out_res.entry_index;
  assign out_entry_size  = out_res.entry_size;
  assign out_data_offset = out_res.data_offset;
  assign out_size_error  = out_res.size_error;
  assign out_found       = out_res.found;

endmodule
